>>> rtl/dfa_pkg.sv
// Shared types and constants for the DFA runner and distinguishability block.
package dfa_pkg;
   localparam int MaxStates  = 16;
   localparam int MaxSymbols = 8;
   localparam int StW        = 4;
   localparam int SymW       = 3;
   localparam int TabDepth   = MaxStates * MaxSymbols;
   localparam int TabAw      = StW + SymW;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_COMPUTE = 2'd1,
      OP_RESTART = 2'd2,
      OP_FEED    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_NUM_STATES  = 2'd0,
      REG_NUM_SYMBOLS = 2'd1,
      REG_START_STATE = 2'd2,
      REG_ACCEPT_MASK = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [4:0]  num_states;
      logic [3:0]  num_symbols;
      logic [3:0]  start_state;
      logic [15:0] accept_mask;
   } cfg_type;
endpackage

>>> rtl/dfa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module dfa_ram #(
   parameter int Width = 4,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> rtl/dfa_csr.sv
// Configuration registers behind the APB-style port.
module dfa_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output dfa_pkg::cfg_type cfg
);
   dfa_pkg::cfg_type cfg_ff;
   logic             wr;
   logic [1:0]       idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_states  <= 5'd16;
         cfg_ff.num_symbols <= 4'd2;
         cfg_ff.start_state <= 4'd0;
         cfg_ff.accept_mask <= 16'd0;
      end else if (wr) begin
         unique case (dfa_pkg::reg_index_type'(idx))
            dfa_pkg::REG_NUM_STATES:  cfg_ff.num_states  <= csr_pwdata[4:0];
            dfa_pkg::REG_NUM_SYMBOLS: cfg_ff.num_symbols <= csr_pwdata[3:0];
            dfa_pkg::REG_START_STATE: cfg_ff.start_state <= csr_pwdata[3:0];
            dfa_pkg::REG_ACCEPT_MASK: cfg_ff.accept_mask <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (dfa_pkg::reg_index_type'(idx))
         dfa_pkg::REG_NUM_STATES:  csr_prdata = {27'd0, cfg_ff.num_states};
         dfa_pkg::REG_NUM_SYMBOLS: csr_prdata = {28'd0, cfg_ff.num_symbols};
         dfa_pkg::REG_START_STATE: csr_prdata = {28'd0, cfg_ff.start_state};
         dfa_pkg::REG_ACCEPT_MASK: csr_prdata = {16'd0, cfg_ff.accept_mask};
         default:                  csr_prdata = 32'd0;
      endcase
   end
   assign cfg = cfg_ff;
endmodule

>>> rtl/dfa_run_and_distinguish.sv
// Top level: DFA runner and table-filling distinguishability engine.
//
//  port group | dir | carries
//  req_*      | in  | tdata {target_state, symbol, from_state}, tuser opcode
//  rsp_*      | out | tdata {distinct_mask, row_state, accepted, current_state}, tlast
//  csr_*      | in  | APB-style register writes and reads
//
// Write: no response. Restart: result in the cycle after accept; feed: result is
// registered in S_FEED from the RAM's registered read. Compute: S_CLEAR zeroes 16 rows,
// S_SEED marks pairs differing in acceptance; per pass over n*(n-1)/2 pairs: S_PAIR,
// S_CHK if marked, else S_PAIR then S_RDP, S_RDQ, S_CHK per symbol tried (up to s),
// until a pass marks nothing, then n rows, one per cycle while rsp_tready is high.
// The distinct matrix lives in flip-flop rows; the transition table is a RAM.
// Reset is synchronous; a held result stalls the block until rsp_tready.
module dfa_run_and_distinguish (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [3:0] from_state, [6:4] symbol, [10:7] target_state
   input  logic [1:0]  req_tuser,  // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [3:0] cur, [4] accepted, [8:5] row_state, [24:9] mask
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   typedef enum logic [3:0] {
      S_IDLE, S_FEED, S_CLEAR, S_SEED, S_PAIR, S_RDP, S_RDQ, S_CHK, S_ROWS
   } st_type;

   dfa_pkg::cfg_type cfg;
   dfa_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .cfg
   );
   assign csr_pready = 1'b1;

   st_type                    state_ff;
   logic [dfa_pkg::StW-1:0]   run_ff;
   logic [dfa_pkg::StW-1:0]   p_ff, q_ff, tp_ff, k_ff;
   logic [2:0]                a_ff;
   logic                      changed_ff, ret_ff;
   logic [15:0]               dm_ff [16];
   logic                      out_v_ff, out_last_ff;
   logic [31:0]               out_data_ff;
   logic                      feed_ok_ff;

   logic [4:0]                n;
   logic [3:0]                s;
   logic [dfa_pkg::TabAw-1:0] rd_addr;
   logic [dfa_pkg::StW-1:0]   rd_data;
   logic                      wr_en;
   logic                      acc;
   logic                      hit;
   logic [dfa_pkg::StW-1:0]   f_from, f_tgt;
   logic [2:0]                f_sym;

   assign f_from = req_tdata[3:0];
   assign f_sym  = req_tdata[6:4];
   assign f_tgt  = req_tdata[10:7];

   always_comb begin
      n = cfg.num_states;
      if (n < 5'd2) n = 5'd2;
      if (n > 5'd16) n = 5'd16;
      s = cfg.num_symbols;
      if (s < 4'd1) s = 4'd1;
      if (s > 4'd8) s = 4'd8;
   end

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign wr_en = req_tvalid && req_tready &&
                  dfa_pkg::opcode_type'(req_tuser) == dfa_pkg::OP_WRITE;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = {run_ff, f_sym};
         S_RDP:   rd_addr = {p_ff, a_ff};
         default: rd_addr = {q_ff, a_ff};
      endcase
   end

   dfa_ram #(.Width(dfa_pkg::StW), .Depth(dfa_pkg::TabDepth)) u_tab (
      .clock, .wr_en, .wr_addr({f_from, f_sym}), .wr_data(f_tgt),
      .rd_addr, .rd_data
   );

   assign acc = cfg.accept_mask[run_ff];
   // predecessor check: tp/tq both in range, distinct, and already marked
   assign hit = ({1'b0, tp_ff} < n) && ({1'b0, rd_data} < n) &&
                (tp_ff != rd_data) && dm_ff[tp_ff][rd_data];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff   <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 16; i++) dm_ff[i] <= '0;
      end else begin
         // row emission sets valid itself when the previous row drains
         if (out_v_ff && rsp_tready && state_ff != S_ROWS) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               unique case (dfa_pkg::opcode_type'(req_tuser))
                  dfa_pkg::OP_WRITE: ;
                  dfa_pkg::OP_COMPUTE: begin
                     k_ff <= '0;
                     state_ff <= S_CLEAR;
                  end
                  dfa_pkg::OP_RESTART: begin
                     run_ff <= cfg.start_state;
                     out_data_ff <= {27'd0, cfg.accept_mask[cfg.start_state],
                                     cfg.start_state};
                     out_last_ff <= 1'b1;
                     out_v_ff <= 1'b1;
                  end
                  dfa_pkg::OP_FEED: begin
                     feed_ok_ff <= ({1'b0, f_sym} < s) && ({1'b0, run_ff} < n);
                     state_ff <= S_FEED;
                  end
                  default: ;
               endcase
            end
            S_FEED: begin
               out_data_ff <= feed_ok_ff ? {27'd0, cfg.accept_mask[rd_data], rd_data}
                                         : {27'd0, acc, run_ff};
               if (feed_ok_ff) run_ff <= rd_data;
               out_last_ff <= 1'b1;
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_CLEAR: begin
               dm_ff[k_ff] <= '0;
               k_ff <= k_ff + 1'b1;
               if (k_ff == 4'd15) state_ff <= S_SEED;
            end
            S_SEED: begin
               for (int i = 0; i < 16; i++)
                  for (int j = 0; j < 16; j++)
                     if (i != j && i < n && j < n &&
                         cfg.accept_mask[i] != cfg.accept_mask[j])
                        dm_ff[i][j] <= 1'b1;
               p_ff <= '0;
               q_ff <= 4'd1;
               changed_ff <= 1'b0;
               state_ff <= S_PAIR;
            end
            S_PAIR: begin
               a_ff <= '0;
               state_ff <= dm_ff[p_ff][q_ff] ? S_CHK : S_RDP;
               ret_ff <= dm_ff[p_ff][q_ff];
            end
            S_RDP: state_ff <= S_RDQ;
            S_RDQ: begin
               tp_ff <= rd_data;
               ret_ff <= 1'b0;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               // ret_ff: pair already marked, skip straight to next pair
               if (!ret_ff && hit) begin
                  dm_ff[p_ff][q_ff] <= 1'b1;
                  dm_ff[q_ff][p_ff] <= 1'b1;
                  changed_ff <= 1'b1;
               end
               if (!ret_ff && !hit && ({1'b0, a_ff} + 4'd1 < s)) begin
                  a_ff <= a_ff + 1'b1;
                  state_ff <= S_RDP;
               end else if ({1'b0, q_ff} + 5'd1 < n) begin
                  q_ff <= q_ff + 1'b1;
                  state_ff <= S_PAIR;
               end else if ({1'b0, p_ff} + 5'd2 < n) begin
                  p_ff <= p_ff + 1'b1;
                  q_ff <= p_ff + 4'd2;
                  state_ff <= S_PAIR;
               end else if (changed_ff || (!ret_ff && hit)) begin
                  p_ff <= '0;
                  q_ff <= 4'd1;
                  changed_ff <= 1'b0;
                  state_ff <= S_PAIR;
               end else begin
                  k_ff <= '0;
                  state_ff <= S_ROWS;
               end
            end
            S_ROWS: if (!out_v_ff || rsp_tready) begin
               out_data_ff <= {7'd0, dm_ff[k_ff], k_ff, 5'd0};
               out_last_ff <= ({1'b0, k_ff} + 5'd1 == n);
               out_v_ff <= 1'b1;
               k_ff <= k_ff + 1'b1;
               if ({1'b0, k_ff} + 5'd1 == n) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule

>>> rtl/dfa_checker.sv
// Port-level checker for the DFA block, bound to the top level.
module dfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with response pending");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == dfa_pkg::OP_RESTART
      |=> rsp_tvalid && rsp_tlast)
      else $error("restart gave no response");
   a_run_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8:5] != 4'd0 |-> rsp_tdata[4:0] == 5'd0)
      else $error("row response carries run fields");
endmodule

bind dfa_run_and_distinguish dfa_checker u_dfa_checker (
   .clock, .reset, .req_tvalid, .req_tready, .req_tuser,
   .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
